>>> design/hbs_pkg.sv
// Shared constants, request codes and stage structures of the height map sampler.
`default_nettype none
package hbs_pkg;

  localparam int FRAC_BITS = 16;
  localparam int MAX_SIDE  = 256;
  localparam int COORD_W   = $clog2(MAX_SIDE);
  localparam int SIDE_W    = COORD_W + 1;
  localparam int ADDR_W    = 2 * COORD_W;
  localparam int DEPTH     = MAX_SIDE * MAX_SIDE;
  localparam int HEIGHT_W  = 16;
  localparam int UNIT_W    = FRAC_BITS + 1;

  localparam logic [SIDE_W-1:0] SIDE_LIMIT = SIDE_W'(MAX_SIDE);
  localparam logic [UNIT_W-1:0] UNIT_ONE   = UNIT_W'(1) << FRAC_BITS;

  localparam logic [0:0] REG_WIDTH  = 1'b0;
  localparam logic [0:0] REG_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    REQ_LOAD     = 2'd0,
    REQ_PIXEL    = 2'd1,
    REQ_BILINEAR = 2'd2
  } req_t;

  // Per-stage control: res marks a word that yields a result.
  typedef struct packed {
    logic res;
    logic bil;
    logic mv;
  } tag_t;

  typedef struct packed {
    logic [ADDR_W-1:0] a00;
    logic [ADDR_W-1:0] a10;
    logic [ADDR_W-1:0] a01;
    logic [ADDR_W-1:0] a11;
  } addr_t;

  typedef struct packed {
    logic                we;
    logic [ADDR_W-1:0]   addr;
    logic [HEIGHT_W-1:0] data;
  } wr_t;

endpackage
`default_nettype wire

>>> design/heightmap_bilinear_sampler_top.sv
// Seven register stages: a sample word passes through the coordinate stages, the
// registered RAM read, the filter stages and the output register.
// Throughput: one word per cycle unless the output stalls; the map is held in four
// replicas, one per neighbour, so the four cell reads of a bilinear sample happen in the same cycle.
// A stalled output holds the whole pipeline; nothing is dropped or repeated.
// Reset clears the valid bits and both size registers; map contents are
// undefined until loaded.
`default_nettype none
module heightmap_bilinear_sampler_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    req_type,
  input  logic [15:0]                   pix_x,
  input  logic [15:0]                   pix_y,
  input  logic [hbs_pkg::HEIGHT_W-1:0]  height_in,
  input  logic [19:0]                   coord_u,
  input  logic [19:0]                   coord_v,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [hbs_pkg::HEIGHT_W-1:0]  height_out,
  output logic                          map_valid,
  input  logic                          cfg_wen,
  input  logic [0:0]                    cfg_index,
  input  logic [hbs_pkg::SIDE_W-1:0]    cfg_wdata
);

  logic [hbs_pkg::SIDE_W-1:0]    map_width, map_height;
  logic [hbs_pkg::SIDE_W-1:0]    w_eff, h_eff;
  logic                          mv, adv;
  hbs_pkg::tag_t                 tag3;
  hbs_pkg::addr_t                addr3;
  hbs_pkg::wr_t                  wr3;
  logic [hbs_pkg::FRAC_BITS-1:0] tx3, ty3;
  logic [hbs_pkg::HEIGHT_W-1:0]  c00, c10, c01, c11;
  logic                          ram_we;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width  <= '0;
      map_height <= '0;
    end else if (cfg_wen) begin
      case (cfg_index)
        hbs_pkg::REG_WIDTH:  map_width  <= cfg_wdata;
        hbs_pkg::REG_HEIGHT: map_height <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    w_eff    = (map_width  > hbs_pkg::SIDE_LIMIT) ? hbs_pkg::SIDE_LIMIT : map_width;
    h_eff    = (map_height > hbs_pkg::SIDE_LIMIT) ? hbs_pkg::SIDE_LIMIT : map_height;
    mv       = (w_eff != '0) && (h_eff != '0);
    adv      = !out_valid || out_ready;
    in_ready = adv;
    ram_we   = wr3.we && adv;
  end

  hbs_coord u_coord (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (in_valid),
    .req_type  (req_type),
    .pix_x     (pix_x),
    .pix_y     (pix_y),
    .height_in (height_in),
    .coord_u   (coord_u),
    .coord_v   (coord_v),
    .w_eff     (w_eff),
    .h_eff     (h_eff),
    .mv        (mv),
    .tag3      (tag3),
    .addr3     (addr3),
    .wr3       (wr3),
    .tx3       (tx3),
    .ty3       (ty3)
  );

  hbs_ram #(.WIDTH(hbs_pkg::HEIGHT_W), .DEPTH(hbs_pkg::DEPTH)) u_ram00 (
    .clk (clk), .we (ram_we), .waddr (wr3.addr), .wdata (wr3.data),
    .re (adv), .raddr (addr3.a00), .rdata (c00)
  );

  hbs_ram #(.WIDTH(hbs_pkg::HEIGHT_W), .DEPTH(hbs_pkg::DEPTH)) u_ram10 (
    .clk (clk), .we (ram_we), .waddr (wr3.addr), .wdata (wr3.data),
    .re (adv), .raddr (addr3.a10), .rdata (c10)
  );

  hbs_ram #(.WIDTH(hbs_pkg::HEIGHT_W), .DEPTH(hbs_pkg::DEPTH)) u_ram01 (
    .clk (clk), .we (ram_we), .waddr (wr3.addr), .wdata (wr3.data),
    .re (adv), .raddr (addr3.a01), .rdata (c01)
  );

  hbs_ram #(.WIDTH(hbs_pkg::HEIGHT_W), .DEPTH(hbs_pkg::DEPTH)) u_ram11 (
    .clk (clk), .we (ram_we), .waddr (wr3.addr), .wdata (wr3.data),
    .re (adv), .raddr (addr3.a11), .rdata (c11)
  );

  hbs_filter u_filter (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .tag3       (tag3),
    .tx3        (tx3),
    .ty3        (ty3),
    .c00        (c00),
    .c10        (c10),
    .c01        (c01),
    .c11        (c11),
    .out_valid  (out_valid),
    .height_out (height_out),
    .map_valid  (map_valid)
  );

endmodule
`default_nettype wire

>>> design/hbs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module hbs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> design/hbs_coord.sv
// Coordinate stages: clamping, scaling to map space and cell address generation.
`default_nettype none
module hbs_coord (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                adv,
  input  logic                                in_valid,
  input  logic [1:0]                          req_type,
  input  logic [15:0]                         pix_x,
  input  logic [15:0]                         pix_y,
  input  logic [hbs_pkg::HEIGHT_W-1:0]        height_in,
  input  logic [19:0]                         coord_u,
  input  logic [19:0]                         coord_v,
  input  logic [hbs_pkg::SIDE_W-1:0]          w_eff,
  input  logic [hbs_pkg::SIDE_W-1:0]          h_eff,
  input  logic                                mv,
  output hbs_pkg::tag_t                       tag3,
  output hbs_pkg::addr_t                      addr3,
  output hbs_pkg::wr_t                        wr3,
  output logic [hbs_pkg::FRAC_BITS-1:0]       tx3,
  output logic [hbs_pkg::FRAC_BITS-1:0]       ty3
);

  function automatic logic [hbs_pkg::COORD_W-1:0] clamp_pix(input logic [15:0] p,
                                                           input logic [hbs_pkg::SIDE_W-1:0] n);
    logic [hbs_pkg::COORD_W-1:0] r;
    if (p[15]) begin
      r = '0;
    end else if (p[14:0] >= 15'(n)) begin
      r = hbs_pkg::COORD_W'(n - 1'b1);
    end else begin
      r = p[hbs_pkg::COORD_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [hbs_pkg::UNIT_W-1:0] clamp_unit(input logic [19:0] c);
    logic [hbs_pkg::UNIT_W-1:0] r;
    if (c[19]) begin
      r = '0;
    end else if (c[18:0] > 19'(hbs_pkg::UNIT_ONE)) begin
      r = hbs_pkg::UNIT_ONE;
    end else begin
      r = c[hbs_pkg::UNIT_W-1:0];
    end
    return r;
  endfunction

  // Stage 1 registers.
  hbs_pkg::tag_t                     tag1;
  logic                              ld1;
  logic [hbs_pkg::COORD_W-1:0]       xc1, yc1;
  logic [hbs_pkg::HEIGHT_W-1:0]      data1;
  logic [hbs_pkg::UNIT_W-1:0]        cu1, cv1;

  // Stage 2 registers.
  hbs_pkg::tag_t                     tag2;
  logic                              ld2;
  logic [hbs_pkg::COORD_W-1:0]       x02, y02;
  logic [hbs_pkg::HEIGHT_W-1:0]      data2;
  logic [hbs_pkg::FRAC_BITS-1:0]     tx2, ty2;

  hbs_pkg::tag_t                     tag1_next;
  logic                              ld1_next;
  hbs_pkg::req_t                     rq;
  logic [hbs_pkg::COORD_W-1:0]       wm1, hm1;
  logic [hbs_pkg::UNIT_W+hbs_pkg::COORD_W-1:0] xs, ys;
  logic [hbs_pkg::COORD_W:0]         x0p, y0p;
  logic [hbs_pkg::COORD_W-1:0]       x1, y1;
  logic [hbs_pkg::SIDE_W+hbs_pkg::COORD_W-1:0] row0, row1;
  hbs_pkg::addr_t                    addr_next;

  always_comb begin
    rq        = hbs_pkg::req_t'(req_type);
    tag1_next = '0;
    ld1_next  = 1'b0;
    tag1_next.mv = mv;
    case (rq)
      hbs_pkg::REQ_LOAD: begin
        ld1_next = in_valid && mv && !pix_x[15] && !pix_y[15] &&
                   (pix_x[14:0] < 15'(w_eff)) && (pix_y[14:0] < 15'(h_eff));
      end
      hbs_pkg::REQ_PIXEL: begin
        tag1_next.res = in_valid;
      end
      hbs_pkg::REQ_BILINEAR: begin
        tag1_next.res = in_valid;
        tag1_next.bil = 1'b1;
      end
      default: begin
        tag1_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1 <= '0;
      ld1  <= 1'b0;
    end else if (adv) begin
      tag1 <= tag1_next;
      ld1  <= ld1_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      xc1   <= clamp_pix(pix_x, w_eff);
      yc1   <= clamp_pix(pix_y, h_eff);
      data1 <= height_in;
      cu1   <= clamp_unit(coord_u);
      cv1   <= clamp_unit(coord_v);
    end
  end

  // Stage 2: scale the unit coordinates by the side length less one (bilinear words only).
  always_comb begin
    wm1 = hbs_pkg::COORD_W'(w_eff - 1'b1);
    hm1 = hbs_pkg::COORD_W'(h_eff - 1'b1);
    xs  = cu1 * wm1;
    ys  = cv1 * hm1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag2 <= '0;
      ld2  <= 1'b0;
    end else if (adv) begin
      tag2 <= tag1;
      ld2  <= ld1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data2 <= data1;
      if (tag1.bil) begin
        x02 <= xs[hbs_pkg::FRAC_BITS +: hbs_pkg::COORD_W];
        y02 <= ys[hbs_pkg::FRAC_BITS +: hbs_pkg::COORD_W];
        tx2 <= xs[hbs_pkg::FRAC_BITS-1:0];
        ty2 <= ys[hbs_pkg::FRAC_BITS-1:0];
      end else begin
        x02 <= xc1;
        y02 <= yc1;
        tx2 <= '0;
        ty2 <= '0;
      end
    end
  end

  // Stage 3: neighbour coordinates and row-major addresses with pitch w.
  always_comb begin
    x0p  = {1'b0, x02} + 1'b1;
    y0p  = {1'b0, y02} + 1'b1;
    x1   = (x0p < w_eff) ? x0p[hbs_pkg::COORD_W-1:0] : hbs_pkg::COORD_W'(w_eff - 1'b1);
    y1   = (y0p < h_eff) ? y0p[hbs_pkg::COORD_W-1:0] : hbs_pkg::COORD_W'(h_eff - 1'b1);
    row0 = y02 * w_eff;
    row1 = y1 * w_eff;
    addr_next.a00 = hbs_pkg::ADDR_W'(row0 + x02);
    addr_next.a10 = hbs_pkg::ADDR_W'(row0 + x1);
    addr_next.a01 = hbs_pkg::ADDR_W'(row1 + x02);
    addr_next.a11 = hbs_pkg::ADDR_W'(row1 + x1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag3   <= '0;
      wr3.we <= 1'b0;
    end else if (adv) begin
      tag3   <= tag2;
      wr3.we <= ld2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      addr3     <= addr_next;
      wr3.addr  <= addr_next.a00;
      wr3.data  <= data2;
      tx3       <= tx2;
      ty3       <= ty2;
    end
  end

endmodule
`default_nettype wire

>>> design/hbs_filter.sv
// Filter stages: horizontal blend, vertical blend, rounding and the output register.
`default_nettype none
module hbs_filter (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            adv,
  input  hbs_pkg::tag_t                   tag3,
  input  logic [hbs_pkg::FRAC_BITS-1:0]   tx3,
  input  logic [hbs_pkg::FRAC_BITS-1:0]   ty3,
  input  logic [hbs_pkg::HEIGHT_W-1:0]    c00,
  input  logic [hbs_pkg::HEIGHT_W-1:0]    c10,
  input  logic [hbs_pkg::HEIGHT_W-1:0]    c01,
  input  logic [hbs_pkg::HEIGHT_W-1:0]    c11,
  output logic                            out_valid,
  output logic [hbs_pkg::HEIGHT_W-1:0]    height_out,
  output logic                            map_valid
);

  localparam int TOP_W = hbs_pkg::HEIGHT_W + hbs_pkg::FRAC_BITS;
  localparam int ACC_W = hbs_pkg::HEIGHT_W + 2 * hbs_pkg::FRAC_BITS;

  // Stage 4 side data, aligned with the registered RAM outputs.
  hbs_pkg::tag_t                   tag4, tag5, tag6;
  logic [hbs_pkg::FRAC_BITS-1:0]   tx4, ty4, ty5;
  logic [TOP_W-1:0]                top5, bot5;
  logic [hbs_pkg::HEIGHT_W-1:0]    pix5, pix6;
  logic [ACC_W-1:0]                acc6;

  logic signed [hbs_pkg::HEIGHT_W:0]       dtop, dbot;
  logic signed [hbs_pkg::HEIGHT_W+hbs_pkg::FRAC_BITS+1:0] ptop, pbot;
  logic [TOP_W+1:0]                        top_sum, bot_sum;
  logic signed [TOP_W:0]                   dver;
  logic signed [TOP_W+hbs_pkg::FRAC_BITS+1:0] pver;
  logic [TOP_W+hbs_pkg::FRAC_BITS+1:0]     acc_sum;
  logic [ACC_W-1:0]                        rnd;
  logic [hbs_pkg::HEIGHT_W-1:0]            res_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag4 <= '0;
      tag5 <= '0;
      tag6 <= '0;
    end else if (adv) begin
      tag4 <= tag3;
      tag5 <= tag4;
      tag6 <= tag5;
    end
  end

  // Each blend is written as a + (b - a) * t so that one multiplier serves a row.
  always_comb begin
    dtop    = $signed({1'b0, c10}) - $signed({1'b0, c00});
    dbot    = $signed({1'b0, c11}) - $signed({1'b0, c01});
    ptop    = dtop * $signed({1'b0, tx4});
    pbot    = dbot * $signed({1'b0, tx4});
    top_sum = {2'b00, c00, hbs_pkg::FRAC_BITS'(0)} + $unsigned(ptop);
    bot_sum = {2'b00, c01, hbs_pkg::FRAC_BITS'(0)} + $unsigned(pbot);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tx4  <= tx3;
      ty4  <= ty3;
      top5 <= top_sum[TOP_W-1:0];
      bot5 <= bot_sum[TOP_W-1:0];
      ty5  <= ty4;
      pix5 <= c00;
    end
  end

  always_comb begin
    dver    = $signed({1'b0, bot5}) - $signed({1'b0, top5});
    pver    = dver * $signed({1'b0, ty5});
    acc_sum = {2'b00, top5, hbs_pkg::FRAC_BITS'(0)} + $unsigned(pver);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      acc6 <= acc_sum[ACC_W-1:0];
      pix6 <= pix5;
    end
  end

  // The blend is never above full scale, so adding the half cannot carry out.
  always_comb begin
    rnd = acc6 + (ACC_W'(1) << (2 * hbs_pkg::FRAC_BITS - 1));
    if (!tag6.mv) begin
      res_next = '0;
    end else if (tag6.bil) begin
      res_next = rnd[2 * hbs_pkg::FRAC_BITS +: hbs_pkg::HEIGHT_W];
    end else begin
      res_next = pix6;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= tag6.res;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      height_out <= res_next;
      map_valid  <= tag6.mv;
    end
  end

endmodule
`default_nettype wire

>>> design/hbs_checker.sv
// Port-level checks of the sampler and the bind that attaches them.
`default_nettype none
module hbs_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_ready,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [hbs_pkg::HEIGHT_W-1:0]  height_out,
  input  logic                          map_valid
);

  // A stalled word keeps its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(height_out) && $stable(map_valid))
    else $error("stalled output word changed");

  // Without a map every sample reads as zero.
  a_nomap: assert property (@(posedge clk) disable iff (rst)
    out_valid && !map_valid |-> height_out == '0)
    else $error("non-zero height without a valid map");

  // An empty output register never blocks the input.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled although the output can move");

  // Nothing is presented in the cycle after reset.
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid straight after reset");

endmodule

bind heightmap_bilinear_sampler_top hbs_checker u_hbs_checker (.*);
`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking testbench for the height map sampler: loads, pixel and bilinear samples.
`timescale 1ns / 100ps
module testbench;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int DRAIN_PAUSE = 16;
  localparam int LONG_HOLD = 150;
  localparam int RANDOM_PER_SIZE = 25;
  localparam int N_SIZES = 8;
  localparam int RND_COLS [N_SIZES] = '{256, 1, 511, 7, 0, 16, 2, 9};
  localparam int RND_ROWS [N_SIZES] = '{1, 256, 1, 5, 256, 16, 128, 13};

  typedef struct {
    logic [1:0]  kind;
    logic [15:0] px;
    logic [15:0] py;
    logic [15:0] hin;
    logic [19:0] cu;
    logic [19:0] cv;
  } sampler_req_t;

  typedef struct {
    logic [hbs_pkg::HEIGHT_W-1:0] height;
    logic                         valid;
  } sample_t;

  logic                         clk;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [1:0]                   req_type = '0;
  logic [15:0]                  pix_x = '0;
  logic [15:0]                  pix_y = '0;
  logic [hbs_pkg::HEIGHT_W-1:0] height_in = '0;
  logic [19:0]                  coord_u = '0;
  logic [19:0]                  coord_v = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [hbs_pkg::HEIGHT_W-1:0] height_out;
  logic                         map_valid;
  logic                         cfg_wen = 1'b0;
  logic [0:0]                   cfg_index = hbs_pkg::REG_WIDTH;
  logic [hbs_pkg::SIDE_W-1:0]   cfg_wdata = '0;

  heightmap_bilinear_sampler_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .pix_x      (pix_x),
    .pix_y      (pix_y),
    .height_in  (height_in),
    .coord_u    (coord_u),
    .coord_v    (coord_v),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .height_out (height_out),
    .map_valid  (map_valid),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // Shadow of the block: size registers and map contents as the block sees them.
  logic [hbs_pkg::SIDE_W-1:0]   cfg_cols = '0;
  logic [hbs_pkg::SIDE_W-1:0]   cfg_rows = '0;
  logic [hbs_pkg::HEIGHT_W-1:0] map_image [hbs_pkg::DEPTH];
  // Cells that the stimulus has already loaded, so that no sample reads an unwritten one.
  bit                           cell_loaded [hbs_pkg::DEPTH];

  sampler_req_t pending_reqs [$];
  sample_t      expected_samples [$];
  sampler_req_t cur_req;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit hold_armed = 1'b0;
  int hold_left = 0;
  int n_loads = 0;
  int n_pixels = 0;
  int n_bilins = 0;
  int n_checked = 0;
  int n_errors = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("Timeout: the sampler stopped making progress.");
    $display("FAIL");
    $finish;
  end

  function automatic int clip_side(input logic [hbs_pkg::SIDE_W-1:0] raw);
    return (raw > hbs_pkg::MAX_SIDE) ? hbs_pkg::MAX_SIDE : int'(raw);
  endfunction

  function automatic int edge_clamp(input logic [15:0] p, input int n);
    int sp;
    sp = $signed(p);
    if (sp < 0) return 0;
    if (sp > n - 1) return n - 1;
    return sp;
  endfunction

  function automatic logic [63:0] unit_clamp(input logic [19:0] c);
    if ($signed(c) < 0) return 64'd0;
    if ($signed(c) > 20'sh10000) return 64'h10000;
    return 64'(c);
  endfunction

  function automatic logic [hbs_pkg::HEIGHT_W-1:0] blend_height(input logic [19:0] cu,
                                                                input logic [19:0] cv,
                                                                input int w, input int h);
    logic [63:0] one, xs, ys, tx, ty, top, bot, acc, rounded;
    int x0, y0, x1, y1;
    one = 64'd1 << hbs_pkg::FRAC_BITS;
    xs = unit_clamp(cu) * 64'(w - 1);
    ys = unit_clamp(cv) * 64'(h - 1);
    x0 = int'(xs >> hbs_pkg::FRAC_BITS);
    y0 = int'(ys >> hbs_pkg::FRAC_BITS);
    tx = xs & (one - 1);
    ty = ys & (one - 1);
    x1 = (x0 + 1 < w) ? x0 + 1 : w - 1;
    y1 = (y0 + 1 < h) ? y0 + 1 : h - 1;
    top = 64'(map_image[y0 * w + x0]) * (one - tx) + 64'(map_image[y0 * w + x1]) * tx;
    bot = 64'(map_image[y1 * w + x0]) * (one - tx) + 64'(map_image[y1 * w + x1]) * tx;
    acc = top * (one - ty) + bot * ty;
    rounded = (acc + (64'd1 << (2 * hbs_pkg::FRAC_BITS - 1))) >> (2 * hbs_pkg::FRAC_BITS);
    return (rounded > 64'hFFFF) ? 16'hFFFF : rounded[15:0];
  endfunction

  // Applies one accepted word to the shadow map and queues the sample it yields.
  task automatic take_request(input sampler_req_t r);
    int w, h, px, py;
    sample_t s;
    w = clip_side(cfg_cols);
    h = clip_side(cfg_rows);
    px = $signed(r.px);
    py = $signed(r.py);
    s.height = '0;
    s.valid = 1'b0;
    case (r.kind)
      hbs_pkg::REQ_LOAD: begin
        n_loads++;
        if (w != 0 && h != 0 && px >= 0 && py >= 0 && px < w && py < h)
          map_image[py * w + px] = r.hin;
      end
      hbs_pkg::REQ_PIXEL, hbs_pkg::REQ_BILINEAR: begin
        if (w != 0 && h != 0) begin
          s.valid = 1'b1;
          if (r.kind == hbs_pkg::REQ_PIXEL) begin
            n_pixels++;
            s.height = map_image[edge_clamp(r.py, h) * w + edge_clamp(r.px, w)];
          end else begin
            n_bilins++;
            s.height = blend_height(r.cu, r.cv, w, h);
          end
        end
        expected_samples.push_back(s);
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) take_request(cur_req);
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          cur_req = pending_reqs.pop_front();
          in_valid  <= 1'b1;
          req_type  <= cur_req.kind;
          pix_x     <= cur_req.px;
          pix_y     <= cur_req.py;
          height_in <= cur_req.hin;
          coord_u   <= cur_req.cu;
          coord_v   <= cur_req.cv;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    sample_t exp_s;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          $display("%0t unexpected sample word: height_out %0d map_valid %0b",
                   $time, height_out, map_valid);
          n_errors++;
        end else begin
          exp_s = expected_samples.pop_front();
          n_checked++;
          if (height_out !== exp_s.height) begin
            $display("%0t height_out mismatch: expected %0d actual %0d",
                     $time, exp_s.height, height_out);
            n_errors++;
          end
          if (map_valid !== exp_s.valid) begin
            $display("%0t map_valid mismatch: expected %0b actual %0b",
                     $time, exp_s.valid, map_valid);
            n_errors++;
          end
        end
      end
      if (hold_armed) begin
        hold_armed = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic push_req(input logic [1:0] kind, input logic [15:0] px, input logic [15:0] py,
                          input logic [15:0] hin, input logic [19:0] cu, input logic [19:0] cv);
    sampler_req_t r;
    r.kind = kind;
    r.px = px;
    r.py = py;
    r.hin = hin;
    r.cu = cu;
    r.cv = cv;
    pending_reqs.push_back(r);
  endtask

  // Sampled on the falling edge so that every update of the rising edge has settled.
  task automatic drain();
    while (pending_reqs.size() != 0 || in_valid || expected_samples.size() != 0)
      @(negedge clk);
    // Loads give no result and may still be in flight.
    repeat (DRAIN_PAUSE) @(negedge clk);
  endtask

  task automatic set_map_size(input int w, input int h);
    drain();
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= hbs_pkg::REG_WIDTH;
    cfg_wdata <= hbs_pkg::SIDE_W'(w);
    cfg_cols = hbs_pkg::SIDE_W'(w);
    @(posedge clk);
    cfg_index <= hbs_pkg::REG_HEIGHT;
    cfg_wdata <= hbs_pkg::SIDE_W'(h);
    cfg_rows = hbs_pkg::SIDE_W'(h);
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  // Loads every cell of the current map that has never been written.
  task automatic fill_map();
    int w, h;
    w = clip_side(cfg_cols);
    h = clip_side(cfg_rows);
    if (w == 0 || h == 0) return;
    for (int y = 0; y < h; y++) begin
      for (int x = 0; x < w; x++) begin
        if (!cell_loaded[y * w + x]) begin
          push_req(hbs_pkg::REQ_LOAD, 16'(x), 16'(y), 16'($urandom), 20'($urandom),
                   20'($urandom));
          cell_loaded[y * w + x] = 1'b1;
        end
      end
    end
  endtask

  // Mostly just around the unit range, with the exact ends and a few wild values.
  function automatic logic [19:0] pick_unit_coord();
    int sel;
    sel = $urandom_range(9);
    if (sel < 7) return 20'($urandom_range(32'h18000)) - 20'h04000;
    if (sel == 7) return $urandom_range(1) ? 20'h10000 : 20'h00000;
    return 20'($urandom);
  endfunction

  task automatic queue_random_req(output bit counted);
    int w, h, sel;
    sampler_req_t r;
    w = clip_side(cfg_cols);
    h = clip_side(cfg_rows);
    r.px = 16'($urandom);
    r.py = 16'($urandom);
    r.hin = 16'($urandom);
    r.cu = 20'($urandom);
    r.cv = 20'($urandom);
    sel = $urandom_range(99);
    counted = 1'b1;
    if (sel < 20) begin
      r.kind = hbs_pkg::REQ_LOAD;
      counted = 1'b0;
      if (sel < 15 && w != 0 && h != 0) begin
        r.px = 16'($urandom_range(w - 1));
        r.py = 16'($urandom_range(h - 1));
      end
      if (w != 0 && h != 0 && $signed(r.px) >= 0 && $signed(r.py) >= 0 &&
          $signed(r.px) < w && $signed(r.py) < h) begin
        cell_loaded[$signed(r.py) * w + $signed(r.px)] = 1'b1;
        counted = 1'b1;
      end
    end else if (sel < 45) begin
      r.kind = hbs_pkg::REQ_PIXEL;
      if (w != 0 && h != 0 && $urandom_range(1) == 1) begin
        r.px = 16'($urandom_range(w - 1));
        r.py = 16'($urandom_range(h - 1));
      end
    end else if (sel < 93) begin
      r.kind = hbs_pkg::REQ_BILINEAR;
      r.cu = pick_unit_coord();
      r.cv = pick_unit_coord();
    end else begin
      r.kind = REQ_UNUSED;
      counted = 1'b0;
    end
    pending_reqs.push_back(r);
  endtask

  initial begin
    int n;
    bit counted;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    tx_idle_pct = 35;
    rx_idle_pct = 73;

    // No map: every sample answers zero and loads are dropped.
    set_map_size(0, 0);
    push_req(hbs_pkg::REQ_PIXEL, 16'd0, 16'd0, 16'd0, 20'd0, 20'd0);
    push_req(hbs_pkg::REQ_BILINEAR, 16'd0, 16'd0, 16'd0, 20'h08000, 20'h08000);
    push_req(hbs_pkg::REQ_LOAD, 16'd0, 16'd0, 16'hFFFF, 20'd0, 20'd0);
    push_req(REQ_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 20'hFFFFF, 20'hFFFFF);
    push_req(hbs_pkg::REQ_PIXEL, 16'd0, 16'd0, 16'd0, 20'd0, 20'd0);
    set_map_size(0, 5);
    push_req(hbs_pkg::REQ_PIXEL, 16'd1, 16'd1, 16'd0, 20'd0, 20'd0);
    push_req(hbs_pkg::REQ_BILINEAR, 16'd0, 16'd0, 16'd0, 20'h10000, 20'd0);
    set_map_size(5, 0);
    push_req(hbs_pkg::REQ_PIXEL, 16'd1, 16'd0, 16'd0, 20'd0, 20'd0);

    // Single cell map, coordinates at the extremes of their fields.
    set_map_size(1, 1);
    fill_map();
    push_req(hbs_pkg::REQ_PIXEL, 16'h8000, 16'h8000, 16'h0000, 20'h00000, 20'h00000);
    push_req(hbs_pkg::REQ_PIXEL, 16'h7FFF, 16'h7FFF, 16'hFFFF, 20'hFFFFF, 20'hFFFFF);
    push_req(hbs_pkg::REQ_BILINEAR, 16'd0, 16'd0, 16'd0, 20'h80000, 20'h7FFFF);
    push_req(hbs_pkg::REQ_BILINEAR, 16'd0, 16'd0, 16'd0, 20'h7FFFF, 20'h80000);
    push_req(hbs_pkg::REQ_LOAD, 16'd1, 16'd0, 16'h1234, 20'd0, 20'd0);
    push_req(hbs_pkg::REQ_LOAD, 16'hFFFF, 16'd0, 16'h1234, 20'd0, 20'd0);
    push_req(hbs_pkg::REQ_PIXEL, 16'd0, 16'd0, 16'd0, 20'd0, 20'd0);

    // Small map: full-scale heights, edge clamping and a blend that lands on a half.
    set_map_size(4, 3);
    fill_map();
    push_req(hbs_pkg::REQ_LOAD, 16'd3, 16'd2, 16'hFFFF, 20'd0, 20'd0);
    push_req(hbs_pkg::REQ_LOAD, 16'd1, 16'd0, 16'h0000, 20'd0, 20'd0);
    push_req(hbs_pkg::REQ_LOAD, 16'd2, 16'd0, 16'h0001, 20'd0, 20'd0);
    push_req(hbs_pkg::REQ_PIXEL, 16'd3, 16'd2, 16'd0, 20'd0, 20'd0);
    push_req(hbs_pkg::REQ_PIXEL, 16'hFFFB, 16'd100, 16'd0, 20'd0, 20'd0);
    push_req(hbs_pkg::REQ_BILINEAR, 16'd0, 16'd0, 16'd0, 20'h10000, 20'h10000);
    push_req(hbs_pkg::REQ_BILINEAR, 16'd0, 16'd0, 16'd0, 20'h10001, 20'hFFFFF);
    push_req(hbs_pkg::REQ_BILINEAR, 16'd0, 16'd0, 16'd0, 20'h08000, 20'h00000);
    push_req(hbs_pkg::REQ_BILINEAR, 16'd0, 16'd0, 16'd0, 20'h05555, 20'h0AAAA);

    for (int i = 0; i < N_SIZES; i++) begin
      set_map_size(RND_COLS[i], RND_ROWS[i]);
      if (i < 3) begin
        tx_idle_pct = 35;
        rx_idle_pct = 73;
      end else if (i < 6) begin
        tx_idle_pct = 73;
        rx_idle_pct = 35;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      fill_map();
      if (i == 6) begin
        // Hold the output off while words keep coming, so the pipeline backs up.
        hold_armed = 1'b1;
        for (int k = 0; k < 40; k++)
          push_req(hbs_pkg::REQ_PIXEL, 16'($urandom), 16'($urandom), 16'($urandom),
                   20'($urandom), 20'($urandom));
      end
      n = 0;
      while (n < RANDOM_PER_SIZE) begin
        queue_random_req(counted);
        n += counted;
      end
    end

    drain();
    $display("Run covered %0d loads, %0d pixel and %0d bilinear samples over %0d map sizes.",
             n_loads, n_pixels, n_bilins, N_SIZES + 5);
    $display("%0d sample words checked, %0d mismatches.", n_checked, n_errors);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
